// File: design/assert_macros.svh
// Assertion macros used by the display queue pointer module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// The expression holds at every clock edge outside reset.
`define DCQ_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// When the antecedent holds, the consequent holds at the same edge.
`define DCQ_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define DCQ_ASSERT(label, expr, msg)
`define DCQ_ASSERT_IMPLY(label, ante, cons, msg)
`endif

`endif

// File: design/dcq_pkg.sv
// Types and constants of the display command queue.
package dcq_pkg;

    localparam int LEVEL_W = 10;

    localparam logic [2:0] ET_COMMAND       = 3'd0;
    localparam logic [2:0] ET_DATA          = 3'd1;
    localparam logic [2:0] ET_DELAY_RESET   = 3'd2;
    localparam logic [2:0] ET_DELAY_RELEASE = 3'd3;

    localparam logic [7:0] FIRST_BIT = 8'h80;

    typedef struct packed {
        logic [2:0] etype;
        logic [7:0] evalue;
    } entry_t;

    typedef struct packed {
        logic sclk;
        logic sdata;
        logic dc;
        logic cs_n;
        logic disp_rst_n;
    } pins_t;

    localparam pins_t PINS_RESET = '{sclk: 1'b0, sdata: 1'b1, dc: 1'b1, cs_n: 1'b1,
                                     disp_rst_n: 1'b0};

    typedef struct packed {
        logic empty;
        logic fetch;
        logic store;
    } ptr_status_t;

    typedef struct packed {
        logic   load;
        entry_t entry;
    } head_load_t;

    typedef enum logic [3:0] {
        PH_DECODE = 4'b0001,
        PH_BIT    = 4'b0010,
        PH_RISE   = 4'b0100,
        PH_FALL   = 4'b1000
    } phase_t;

endpackage

// File: design/spi_display_command_queue_core.sv
// Top level of the display command queue with its result register.
// A ring queue of command, data and delay entries drives a 4-wire serial
// display link, one link tick per tick word, and every accepted word
// (enqueue or tick) yields one result word with the pin levels, the queue
// level and whether an enqueue was stored. The result word is presented in
// the cycle after its input word is taken. A word is taken in every cycle,
// except in the cycle after a tick that retires an entry while others still
// wait: in that cycle the queue memory's registered read port loads the next
// head entry and in_stall is high. An enqueue into a full queue is dropped
// and reported with accepted low. The result register lets the next word in
// while a result waits, so the input stalls on the output only when a result
// is held and out_stall is high. No memory clearing is needed after reset.
module spi_display_command_queue_core #(
    parameter int QUEUE_DEPTH = 512
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [2:0] entry_type,
    input  logic [7:0] entry_value,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       serial_clock,
    output logic       serial_data,
    output logic       data_not_command,
    output logic       chip_select_n,
    output logic       reset_n,
    output logic       backlight,
    output logic [9:0] queue_level,
    output logic       accepted
);
    import dcq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                backlight_reg;
    logic                out_valid_reg;
    pins_t               pins_out_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic                accepted_reg;

    logic                accept;
    logic                do_enq;
    logic                do_tick;
    logic                tick_go;
    logic                pop;
    ptr_status_t         status;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;
    logic [CW-1:0]       count_next;
    entry_t              in_entry;
    entry_t              mem_rdata;
    head_load_t          head_load;
    pins_t               pins_next;

    assign in_stall = status.fetch | (out_valid_reg & out_stall);
    assign accept   = in_valid & ~in_stall;
    assign do_enq   = accept & ~kind;
    assign do_tick  = accept & kind;
    assign tick_go  = do_tick & ~status.empty;

    assign in_entry.etype  = entry_type;
    assign in_entry.evalue = entry_value;

    assign head_load.load  = (status.store & status.empty) | status.fetch;
    assign head_load.entry = status.fetch ? mem_rdata : in_entry;

    dcq_ptrs #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ptrs (
        .clk        (clk),
        .rst_n      (rst_n),
        .enq        (do_enq),
        .pop        (pop),
        .status     (status),
        .wr_addr    (wr_addr),
        .rd_addr    (rd_addr),
        .count_next (count_next)
    );

    dcq_store #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (status.store),
        .waddr (wr_addr),
        .wdata (in_entry),
        .raddr (rd_addr),
        .rdata (mem_rdata)
    );

    dcq_link u_link (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_go   (tick_go),
        .head_load (head_load),
        .pop       (pop),
        .pins_next (pins_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backlight_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                backlight_reg <= cfg_wdata;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pins_out_reg <= pins_next;
            level_reg    <= LEVEL_W'(count_next);
            accepted_reg <= status.store;
        end
    end

    assign out_valid        = out_valid_reg;
    assign serial_clock     = pins_out_reg.sclk;
    assign serial_data      = pins_out_reg.sdata;
    assign data_not_command = pins_out_reg.dc;
    assign chip_select_n    = pins_out_reg.cs_n;
    assign reset_n          = pins_out_reg.disp_rst_n;
    assign backlight        = backlight_reg;
    assign queue_level      = level_reg;
    assign accepted         = accepted_reg;

endmodule

// File: design/dcq_store.sv
// Entry memory of the queue: one write port and one registered read port.
module dcq_store #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  dcq_pkg::entry_t wdata,
    input  logic [AW-1:0]   raddr,
    output dcq_pkg::entry_t rdata
);
    import dcq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/dcq_ptrs.sv
// Head, tail and fill count of the ring queue, and the head refetch flag.
`include "assert_macros.svh"

module dcq_ptrs #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int CW    = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 enq,
    input  logic                 pop,
    output dcq_pkg::ptr_status_t status,
    output logic [AW-1:0]        wr_addr,
    output logic [AW-1:0]        rd_addr,
    output logic [CW-1:0]        count_next
);
    import dcq_pkg::*;

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg;
    logic          fetch_reg, fetch_next;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] tail_inc;
    logic          full;
    logic          store;

    assign full     = (count_reg == CW'(DEPTH));
    assign store    = enq & ~full;
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        fetch_next = 1'b0;
        if (store)
        begin
            tail_next  = tail_inc;
            count_next = count_reg + 1'b1;
        end
        else if (pop)
        begin
            head_next  = head_inc;
            count_next = count_reg - 1'b1;
            fetch_next = (count_reg != CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            fetch_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            fetch_reg <= fetch_next;
        end
    end

    assign status.empty = (count_reg == '0);
    assign status.fetch = fetch_reg;
    assign status.store = store;
    assign wr_addr      = tail_reg;
    assign rd_addr      = head_inc;

    `DCQ_ASSERT(a_count_bound, count_reg <= CW'(DEPTH), "Queue count exceeds depth.")
    `DCQ_ASSERT_IMPLY(a_fetch_nonempty, fetch_reg, count_reg != '0,
        "Head refetch pending on an empty queue.")
    `DCQ_ASSERT_IMPLY(a_pop_legal, pop, !fetch_reg && count_reg != '0,
        "Entry retired while the head is not loaded.")
    `DCQ_ASSERT_IMPLY(a_no_mix, enq, !pop, "Enqueue and retire in the same cycle.")

endmodule

// File: design/dcq_link.sv
// Link sequencer: head entry copy, bit phase, bit mask and display pin levels.
module dcq_link (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick_go,
    input  dcq_pkg::head_load_t head_load,
    output logic                pop,
    output dcq_pkg::pins_t      pins_next
);
    import dcq_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] mask_reg, mask_next;
    pins_t      pins_reg;
    logic [2:0] htype_reg, htype_next;
    logic [7:0] hvalue_reg, hvalue_next;

    always_comb
    begin
        phase_next  = phase_reg;
        mask_next   = mask_reg;
        pins_next   = pins_reg;
        htype_next  = htype_reg;
        hvalue_next = hvalue_reg;
        pop         = 1'b0;
        if (head_load.load)
        begin
            htype_next  = head_load.entry.etype;
            hvalue_next = head_load.entry.evalue;
        end
        if (tick_go)
        begin
            unique case (phase_reg)
                PH_DECODE:
                begin
                    if (htype_reg == ET_COMMAND || htype_reg == ET_DATA)
                    begin
                        pins_next.dc         = (htype_reg == ET_DATA);
                        pins_next.disp_rst_n = 1'b1;
                        pins_next.cs_n       = 1'b0;
                        mask_next            = FIRST_BIT;
                        phase_next           = PH_BIT;
                    end
                    else
                    begin
                        // Delays and unknown types count down; the delay types also drive the display reset.
                        if (htype_reg == ET_DELAY_RESET)
                        begin
                            pins_next.disp_rst_n = 1'b0;
                        end
                        if (hvalue_reg != '0)
                        begin
                            hvalue_next = hvalue_reg - 8'd1;
                        end
                        else
                        begin
                            if (htype_reg == ET_DELAY_RELEASE)
                            begin
                                pins_next.disp_rst_n = 1'b1;
                            end
                            pop = 1'b1;
                        end
                    end
                end
                PH_BIT:
                begin
                    if (mask_reg != '0)
                    begin
                        phase_next      = PH_RISE;
                        pins_next.sdata = |(hvalue_reg & mask_reg);
                        mask_next       = mask_reg >> 1;
                    end
                    else
                    begin
                        pins_next.cs_n = 1'b1;
                        phase_next     = PH_DECODE;
                        pop            = 1'b1;
                    end
                end
                PH_RISE:
                begin
                    phase_next     = PH_FALL;
                    pins_next.sclk = 1'b1;
                end
                PH_FALL:
                begin
                    phase_next     = PH_BIT;
                    pins_next.sclk = 1'b0;
                end
                default:
                begin
                    phase_next = PH_DECODE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DECODE;
            mask_reg  <= FIRST_BIT;
            pins_reg  <= PINS_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            mask_reg  <= mask_next;
            pins_reg  <= pins_next;
        end
    end

    always_ff @(posedge clk)
    begin
        htype_reg  <= htype_next;
        hvalue_reg <= hvalue_next;
    end

endmodule
